[hw/rtl/hkrq_pkg.sv]
// Package for the keyboard report queue: sizes, operation codes,
// the report layout and the controller-to-datapath command struct.
// Depends on nothing; every other file of the block imports it.
package hkrq_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int REPORT_KEYS = 6;
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        OP_PRESS       = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_RELEASE_ALL = 3'd2,
        OP_SET_MOD     = 3'd3,
        OP_CLEAR_MOD   = 3'd4,
        OP_SEND        = 3'd5
    } t_op;

    // Boot-keyboard report without the reserved byte, which is always zero.
    typedef struct packed {
        logic [7:0]                  modifier;
        logic [REPORT_KEYS-1:0][7:0] keys;
    } t_report;

    typedef struct packed {
        logic load;
    } t_ctrl_cmd;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

endpackage

[hw/rtl/hkrq_ctrl.sv]
// Controller of the keyboard report queue: request handshakes and sequencing.
// Depends on hkrq_pkg.
module hkrq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hkrq_pkg::t_ctrl_cmd o_cmd
);
    import hkrq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_OUT  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_cmd.load  = (r_state == ST_IDLE) && i_in_valid;

    a_load_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_out_valid)
        else $error("accepted request did not produce a result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input taken while a result is pending");

    a_hold_until_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before it was taken");

endmodule

[hw/rtl/hkrq_dp.sv]
// Datapath of the keyboard report queue: held-key table, modifier byte,
// report ring memory and the result registers. Depends on hkrq_pkg.
module hkrq_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hkrq_pkg::t_ctrl_cmd i_cmd,
    input  logic [2:0]          i_op,
    input  logic [7:0]          i_key_or_mask,
    input  logic                i_host_configured,
    input  logic                i_endpoint_ready,
    output logic                o_op_ok,
    output logic                o_report_valid,
    output hkrq_pkg::t_report   o_report
);
    import hkrq_pkg::*;

    logic [KEY_SLOTS-1:0][7:0] r_held;
    logic [KEY_SLOTS-1:0][7:0] n_held;
    logic [7:0]                r_mod;
    logic [7:0]                n_mod;
    logic [PTR_W-1:0]          r_wp;
    logic [PTR_W-1:0]          n_wp;
    logic [PTR_W-1:0]          r_rp;
    logic [PTR_W-1:0]          n_rp;

    t_report r_ring [QUEUE_DEPTH];
    t_report r_rd_data;
    t_report r_snap;
    logic    r_ok;
    logic    r_pop;
    logic    r_bypass;
    logic    n_ok;
    logic    n_pop;
    logic    n_bypass;
    logic    push;

    t_report          snapshot;
    logic             any_match;
    logic             any_zero;
    logic             done;
    logic [PTR_W-1:0] wp_after;

    always_comb begin
        snapshot.modifier = r_mod;
        for (int i = 0; i < REPORT_KEYS; i++) begin
            if (i < KEY_SLOTS) begin
                snapshot.keys[i] = r_held[i];
            end else begin
                snapshot.keys[i] = '0;
            end
        end
    end

    always_comb begin
        any_match = 1'b0;
        any_zero  = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_held[i] == i_key_or_mask) begin
                any_match = 1'b1;
            end
            if (r_held[i] == 8'd0) begin
                any_zero = 1'b1;
            end
        end
    end

    always_comb begin
        n_held   = r_held;
        n_mod    = r_mod;
        n_rp     = r_rp;
        n_ok     = 1'b0;
        n_pop    = 1'b0;
        n_bypass = 1'b0;
        push     = 1'b0;
        done     = 1'b0;
        wp_after = r_wp;
        unique case (i_op)
            OP_PRESS: begin
                if (any_match) begin
                    n_ok = 1'b1;
                end else if (any_zero) begin
                    n_ok = 1'b1;
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (!done && r_held[i] == 8'd0) begin
                            n_held[i] = i_key_or_mask;
                            done      = 1'b1;
                        end
                    end
                end
            end
            OP_RELEASE: begin
                n_ok = any_match;
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (!done && r_held[i] == i_key_or_mask) begin
                        n_held[i] = '0;
                        done      = 1'b1;
                    end
                end
            end
            OP_RELEASE_ALL: begin
                n_held = '0;
                n_mod  = '0;
            end
            OP_SET_MOD: begin
                n_mod = r_mod | i_key_or_mask;
            end
            OP_CLEAR_MOD: begin
                n_mod = r_mod & ~i_key_or_mask;
            end
            OP_SEND: begin
                n_ok = i_host_configured && i_endpoint_ready;
                // A full ring drops the snapshot but still reports success.
                push = n_ok && (ptr_next(r_wp) != r_rp);
                if (push) begin
                    wp_after = ptr_next(r_wp);
                end
                n_pop = i_endpoint_ready && (wp_after != r_rp);
                // Empty ring before the push: the popped report is this snapshot.
                n_bypass = n_pop && (r_wp == r_rp);
                if (n_pop) begin
                    n_rp = ptr_next(r_rp);
                end
            end
            default: begin
            end
        endcase
        n_wp = wp_after;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_mod  <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_ok   <= 1'b0;
            r_pop  <= 1'b0;
        end else if (i_cmd.load) begin
            r_held <= n_held;
            r_mod  <= n_mod;
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_ok   <= n_ok;
            r_pop  <= n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bypass  <= n_bypass;
            r_snap    <= snapshot;
            r_rd_data <= r_ring[r_rp];
            if (push) begin
                r_ring[r_wp] <= snapshot;
            end
        end
    end

    assign o_op_ok        = r_ok;
    assign o_report_valid = r_pop;
    assign o_report       = !r_pop ? '0 : (r_bypass ? r_snap : r_rd_data);

    a_ptrs_only_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_op != OP_SEND) |=> ($stable(r_wp) && $stable(r_rp)))
        else $error("queue pointers moved on a non-send request");

    a_no_pop_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && !i_endpoint_ready) |=> !r_pop)
        else $error("report popped while endpoint not ready");

    a_table_kept_on_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && i_op == OP_SEND) |=> ($stable(r_held) && $stable(r_mod)))
        else $error("send changed the key table");

endmodule

[hw/rtl/hid_keyboard_report_queue.sv]
// A request accepted at a clock edge presents its result from the cycle after that edge.
// A new request is accepted only once the previous result has been taken, since the
// controller alternates between taking a request and holding its result. A stalled
// result holds off the next request.
// Reset (i_rst_n low at a clock edge) clears the key table, the modifiers and both
// ring pointers; ring contents are not cleared and are only read once written.
// Depends on hkrq_pkg, hkrq_ctrl and hkrq_dp.
module hid_keyboard_report_queue (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Request channel.
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [2:0] i_op,
    input  logic [7:0] i_key_or_mask,
    input  logic       i_host_configured,
    input  logic       i_endpoint_ready,
    // Result channel.
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_op_ok,
    output logic       o_report_valid,
    output logic [7:0] o_report_modifier,
    output logic [7:0] o_report_key_a,
    output logic [7:0] o_report_key_b,
    output logic [7:0] o_report_key_c,
    output logic [7:0] o_report_key_d,
    output logic [7:0] o_report_key_e,
    output logic [7:0] o_report_key_f
);
    import hkrq_pkg::*;

    // The controller holds only its sequencing state; every other piece of state lives
    // in the datapath and is updated only in the cycle in which a request is
    // accepted.
    t_ctrl_cmd cmd;
    t_report   report;

    hkrq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the six-slot table, the modifier byte and the
    // ring of queued reports. A successful send pushes a snapshot unless the ring
    // is full, then pops at most one report; when the ring was empty the popped
    // report is the snapshot itself and comes straight from a holding register.
    hkrq_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_op              (i_op),
        .i_key_or_mask     (i_key_or_mask),
        .i_host_configured (i_host_configured),
        .i_endpoint_ready  (i_endpoint_ready),
        .o_op_ok           (o_op_ok),
        .o_report_valid    (o_report_valid),
        .o_report          (report)
    );

    // Key slots map onto the report bytes in order; the fields read zero
    // when no report is popped.
    assign o_report_modifier = report.modifier;
    assign o_report_key_a    = report.keys[0];
    assign o_report_key_b    = report.keys[1];
    assign o_report_key_c    = report.keys[2];
    assign o_report_key_d    = report.keys[3];
    assign o_report_key_e    = report.keys[4];
    assign o_report_key_f    = report.keys[5];

endmodule

[tb/sv/hid_keyboard_report_queue_tb.sv]
// Self-checking testbench for hid_keyboard_report_queue: directed table plus random requests,
// results checked against an in-bench model of the key table and report ring or a typed result.
// Depends on hkrq_pkg and the hid_keyboard_report_queue RTL.
`timescale 1ns / 1ps

module hid_keyboard_report_queue_tb;
    import hkrq_pkg::*;

    // Op codes the block must ignore; they have no name in the package.
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam int RANDOM_ITEMS = 700;
    localparam int PLAN_ROWS    = 25;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 50;

    // Everything one request produces: the status bit and the popped report, if any.
    typedef struct packed {
        logic    ok;
        logic    valid;
        t_report rpt;
    } t_reply;

    // One row of the directed table. When typed is set, want holds the result
    // written out by hand; otherwise the model supplies it.
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] val;
        logic       cfg;
        logic       rdy;
        logic       typed;
        t_reply     want;
    } t_row;

    localparam logic   TYPED     = 1'b1;
    localparam logic   PREDICTED = 1'b0;
    localparam t_reply NO_REPLY  = '0;
    localparam t_reply ACK_ONLY  = '{ok: 1'b1, valid: 1'b0, rpt: '0};

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [2:0] i_op;
    logic [7:0] i_key_or_mask;
    logic       i_host_configured;
    logic       i_endpoint_ready;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_op_ok;
    logic       o_report_valid;
    logic [7:0] o_report_modifier;
    logic [7:0] o_report_key_a;
    logic [7:0] o_report_key_b;
    logic [7:0] o_report_key_c;
    logic [7:0] o_report_key_d;
    logic [7:0] o_report_key_e;
    logic [7:0] o_report_key_f;

    hid_keyboard_report_queue u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_key_or_mask     (i_key_or_mask),
        .i_host_configured (i_host_configured),
        .i_endpoint_ready  (i_endpoint_ready),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_op_ok           (o_op_ok),
        .o_report_valid    (o_report_valid),
        .o_report_modifier (o_report_modifier),
        .o_report_key_a    (o_report_key_a),
        .o_report_key_b    (o_report_key_b),
        .o_report_key_c    (o_report_key_c),
        .o_report_key_d    (o_report_key_d),
        .o_report_key_e    (o_report_key_e),
        .o_report_key_f    (o_report_key_f)
    );

    // Model state: the held-key table, the modifier mask and the report ring.
    logic [7:0]       slot_code [KEY_SLOTS];
    logic [7:0]       mod_mask;
    t_report          report_fifo [QUEUE_DEPTH];
    logic [PTR_W-1:0] fifo_wr;
    logic [PTR_W-1:0] fifo_rd;

    // Results still owed by the block, oldest first, and their count for wait statements.
    t_reply pending_replies [$];
    int     in_flight;

    // Sideband that travels with each request: a hand-written result, when there is one.
    logic   use_typed;
    t_reply typed_reply;

    logic   steady;          // high during the stretch where neither side idles
    int     mismatch_count;
    int     replies_seen;
    int     cycle_count;
    t_row   plan [PLAN_ROWS];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Any run that is still going after the limit has hung somewhere.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("hid_keyboard_report_queue test failed");
            $finish;
        end
    end

    // Result side: ready drops with a chance of about 32 in a hundred, except in the steady stretch.
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 32);
    end

    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
        return PTR_W'((int'(p) + 1) % QUEUE_DEPTH);
    endfunction

    // Applies one request to the model state and returns the result it must produce.
    function automatic t_reply keyboard_step(input logic [2:0] op, input logic [7:0] val,
                                             input logic cfg, input logic rdy);
        t_reply           r;
        logic             hit;
        logic [PTR_W-1:0] nxt;
        r   = NO_REPLY;
        hit = 1'b0;
        case (op)
            OP_PRESS: begin
                // A code that is already held counts as success; zero matches an empty slot.
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (slot_code[i] == val) hit = 1'b1;
                end
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (!hit && slot_code[i] == 8'h00) begin
                        slot_code[i] = val;
                        hit = 1'b1;
                    end
                end
                r.ok = hit;
            end
            OP_RELEASE: begin
                for (int i = 0; i < KEY_SLOTS; i++) begin
                    if (!hit && slot_code[i] == val) begin
                        slot_code[i] = 8'h00;
                        hit = 1'b1;
                    end
                end
                r.ok = hit;
            end
            OP_RELEASE_ALL: begin
                for (int i = 0; i < KEY_SLOTS; i++) slot_code[i] = 8'h00;
                mod_mask = 8'h00;
            end
            OP_SET_MOD:   mod_mask = mod_mask | val;
            OP_CLEAR_MOD: mod_mask = mod_mask & ~val;
            OP_SEND: begin
                if (cfg && rdy) begin
                    // The snapshot is dropped when the ring is full, but op_ok stays set.
                    nxt = ring_advance(fifo_wr);
                    if (nxt != fifo_rd) begin
                        report_fifo[fifo_wr]          = '0;
                        report_fifo[fifo_wr].modifier = mod_mask;
                        for (int i = 0; i < REPORT_KEYS && i < KEY_SLOTS; i++) begin
                            report_fifo[fifo_wr].keys[i] = slot_code[i];
                        end
                        fifo_wr = nxt;
                    end
                    r.ok = 1'b1;
                end
                if (rdy && fifo_wr != fifo_rd) begin
                    r.valid = 1'b1;
                    r.rpt   = report_fifo[fifo_rd];
                    fifo_rd = ring_advance(fifo_rd);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] want,
                                   input logic [7:0] got);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("result %0d: %s expected %h, got %h", replies_seen, field, want, got);
        end
        mismatch_count++;
    endtask

    // Request and result monitor. Both sides are sampled at the rising edge, before any
    // driver update of that edge lands, so each request is seen with its own payload.
    always @(posedge i_clk) begin : scoreboard
        t_reply     want;
        t_reply     guess;
        logic [7:0] seen [REPORT_KEYS];
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_SLOTS; i++) slot_code[i] = 8'h00;
            mod_mask = 8'h00;
            fifo_wr  = '0;
            fifo_rd  = '0;
            pending_replies.delete();
            in_flight = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                // The model always advances, even when the row carries its own answer.
                guess = keyboard_step(i_op, i_key_or_mask, i_host_configured,
                                      i_endpoint_ready);
                pending_replies.push_back(use_typed ? typed_reply : guess);
                in_flight++;
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("result with no request outstanding, op_ok", 8'h00,
                                    {7'd0, o_op_ok});
                end else begin
                    want = pending_replies.pop_front();
                    in_flight--;
                    seen = '{o_report_key_a, o_report_key_b, o_report_key_c,
                             o_report_key_d, o_report_key_e, o_report_key_f};
                    if (o_op_ok !== want.ok) begin
                        report_mismatch("op_ok", {7'd0, want.ok}, {7'd0, o_op_ok});
                    end
                    if (o_report_valid !== want.valid) begin
                        report_mismatch("report_valid", {7'd0, want.valid},
                                        {7'd0, o_report_valid});
                    end
                    if (o_report_modifier !== want.rpt.modifier) begin
                        report_mismatch("report_modifier", want.rpt.modifier,
                                        o_report_modifier);
                    end
                    for (int i = 0; i < REPORT_KEYS; i++) begin
                        if (seen[i] !== want.rpt.keys[i]) begin
                            report_mismatch($sformatf("report key slot %0d", i),
                                            want.rpt.keys[i], seen[i]);
                        end
                    end
                end
                replies_seen++;
            end
        end
    end

    // Presents one request and returns at the edge where it is accepted. Valid stays
    // high into the next request unless a random gap is taken.
    task automatic push_request(input logic [2:0] op, input logic [7:0] val,
                                input logic cfg, input logic rdy,
                                input logic typed, input t_reply want,
                                input logic may_idle);
        int gap;
        gap = 0;
        if (may_idle && $urandom_range(0, 99) < 32) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_op              <= op;
        i_key_or_mask     <= val;
        i_host_configured <= cfg;
        i_endpoint_ready  <= rdy;
        use_typed         <= typed;
        typed_reply       <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Holds off new requests until every owed result has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        wait (in_flight == 0);
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [2:0] op;
        logic [7:0] val;
        logic       cfg;
        logic       rdy;
        int         pick;
        logic       calm;

        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_op              = OP_PRESS;
        i_key_or_mask     = 8'h00;
        i_host_configured = 1'b0;
        i_endpoint_ready  = 1'b0;
        i_out_ready       = 1'b0;
        use_typed         = 1'b0;
        typed_reply       = NO_REPLY;
        steady            = 1'b0;
        mismatch_count    = 0;
        replies_seen      = 0;
        cycle_count       = 0;
        in_flight         = 0;

        // Directed walk: sends with nothing queued, duplicate and zero presses, modifier
        // mask updates, filling the table, releases of missing and zero codes, the
        // ignored op codes, release-all and a snapshot of the cleared table.
        plan = '{
            '{OP_SEND,        8'h00, 1'b0, 1'b1, TYPED,     NO_REPLY},
            '{OP_SEND,        8'hFF, 1'b1, 1'b0, TYPED,     NO_REPLY},
            '{OP_PRESS,       8'h04, 1'b0, 1'b0, TYPED,     ACK_ONLY},
            '{OP_PRESS,       8'hFF, 1'b1, 1'b1, TYPED,     ACK_ONLY},
            '{OP_PRESS,       8'h04, 1'b0, 1'b1, PREDICTED, NO_REPLY},
            '{OP_PRESS,       8'h00, 1'b1, 1'b0, TYPED,     ACK_ONLY},
            '{OP_SET_MOD,     8'hFF, 1'b0, 1'b0, TYPED,     NO_REPLY},
            '{OP_CLEAR_MOD,   8'h55, 1'b1, 1'b1, TYPED,     NO_REPLY},
            '{OP_SEND,        8'h00, 1'b1, 1'b1, PREDICTED, NO_REPLY},
            '{OP_PRESS,       8'h01, 1'b0, 1'b0, PREDICTED, NO_REPLY},
            '{OP_PRESS,       8'h80, 1'b0, 1'b0, PREDICTED, NO_REPLY},
            '{OP_PRESS,       8'h7F, 1'b0, 1'b0, PREDICTED, NO_REPLY},
            '{OP_PRESS,       8'h10, 1'b0, 1'b0, PREDICTED, NO_REPLY},
            '{OP_PRESS,       8'h20, 1'b0, 1'b0, PREDICTED, NO_REPLY},
            '{OP_PRESS,       8'h00, 1'b0, 1'b0, PREDICTED, NO_REPLY},
            '{OP_RELEASE,     8'h00, 1'b0, 1'b0, PREDICTED, NO_REPLY},
            '{OP_RELEASE,     8'h33, 1'b0, 1'b0, PREDICTED, NO_REPLY},
            '{OP_SEND,        8'h00, 1'b1, 1'b1, PREDICTED, NO_REPLY},
            '{OP_RELEASE,     8'hFF, 1'b0, 1'b0, PREDICTED, NO_REPLY},
            '{OP_RELEASE,     8'h00, 1'b0, 1'b0, PREDICTED, NO_REPLY},
            '{OP_UNUSED_6,    8'hAA, 1'b1, 1'b1, TYPED,     NO_REPLY},
            '{OP_UNUSED_7,    8'hFF, 1'b1, 1'b1, TYPED,     NO_REPLY},
            '{OP_RELEASE_ALL, 8'h00, 1'b1, 1'b1, TYPED,     NO_REPLY},
            '{OP_SEND,        8'h00, 1'b1, 1'b1, PREDICTED, NO_REPLY},
            '{OP_SEND,        8'h00, 1'b0, 1'b1, TYPED,     NO_REPLY}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++) begin
            push_request(plan[r].op, plan[r].val, plan[r].cfg, plan[r].rdy,
                         plan[r].typed, plan[r].want, 1'b1);
        end
        drain_results();

        // Random requests. Key codes mostly come from a small pool so that duplicates,
        // full tables and successful releases are common; sends are mostly to a
        // configured host with a ready endpoint, which walks the ring pointers around.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n >= 250 && n < 400);
            steady <= calm;
            if (n == 450) drain_results();
            pick = $urandom_range(0, 99);
            cfg  = 1'($urandom_range(0, 1));
            rdy  = 1'($urandom_range(0, 1));
            val  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 9));
            if (pick < 32) begin
                op = OP_PRESS;
            end else if (pick < 52) begin
                op = OP_RELEASE;
            end else if (pick < 57) begin
                op = OP_RELEASE_ALL;
            end else if (pick < 65) begin
                op  = OP_SET_MOD;
                val = 8'($urandom_range(0, 255));
            end else if (pick < 72) begin
                op  = OP_CLEAR_MOD;
                val = 8'($urandom_range(0, 255));
            end else if (pick < 97) begin
                op  = OP_SEND;
                cfg = ($urandom_range(0, 9) != 0);
                rdy = ($urandom_range(0, 5) != 0);
            end else begin
                op = ($urandom_range(0, 1) == 0) ? OP_UNUSED_6 : OP_UNUSED_7;
            end
            push_request(op, val, cfg, rdy, PREDICTED, NO_REPLY, !calm);
        end
        steady <= 1'b0;

        // Let every owed result arrive, then idle on to catch stray results.
        drain_results();
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("hid_keyboard_report_queue test passed");
        end else begin
            $display("hid_keyboard_report_queue test failed");
        end
        $finish;
    end

endmodule
